@@ hw/rtl/cdrs_pkg.sv @@
// Shared types and constants of the circular-scan disk head scheduler.
package cdrs_pkg;

    localparam int unsigned PENDING_SLOTS_DEFAULT = 16;
    localparam logic [15:0] MAX_CYLINDER_RESET    = 16'd199;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_RELEASE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        STAT_GRANTED = 3'd0,
        STAT_QUEUED  = 3'd1,
        STAT_INVALID = 3'd2,
        STAT_FULL    = 3'd3,
        STAT_IDLE    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT,
        ST_RESULT
    } state_t;

    // One pending request as held in the slot memory.
    typedef struct packed {
        logic [15:0] arrival;
        logic        sweep;
        logic [7:0]  requester;
        logic [15:0] cylinder;
    } entry_t;

    // Best candidate found so far in one sweep.
    typedef struct packed {
        logic        found;
        logic [15:0] cylinder;
        logic [7:0]  requester;
        logic [15:0] age;
    } cand_t;

    typedef struct packed {
        logic load;
        logic fast_commit;
        logic scan_start;
        logic scan_issue;
        logic commit;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic fast_path;
        logic scan_last;
    } dp_status_t;

endpackage

@@ hw/rtl/cscan_disk_request_scheduler_unit.sv @@
// Top level of the circular-scan disk head scheduler with its output register.
//
// Each item is a request for a cylinder or a release of the head, and gives
// exactly one result item. A request that is out of range, or that finds the
// head idle, is answered from the check state without a scan. Every other
// request and every release walks all PENDING_SLOTS pending slots through the
// single read port of the slot memory, one slot a cycle, and then passes
// through the drain and commit states to the result state. One item is worked
// on at a time; the next item is accepted in the cycle after the previous
// result has been loaded into the output register, even while that result
// waits to be taken. The highest valid cylinder is written through the cfg
// port, which is always ready.
module cscan_disk_request_scheduler_unit #(
    parameter int unsigned PENDING_SLOTS = cdrs_pkg::PENDING_SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] cylinder, [23:16] requester_id
    input  logic [0:0]  s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [7:0] grant_id, [23:8] grant_cylinder
    output logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    cdrs_pkg::ctrl_cmd_t  cmd;
    cdrs_pkg::dp_status_t dp_status;
    logic [2:0]           res_status;
    logic [7:0]           res_grant_id;
    logic [15:0]          res_grant_cylinder;
    logic                 out_free;
    logic                 m_tvalid_reg;
    logic [23:0]          m_tdata_reg;
    logic [2:0]           m_tuser_reg;

    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    cdrs_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .out_free  (out_free),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    cdrs_dp #(
        .PENDING_SLOTS (PENDING_SLOTS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .dp_status          (dp_status),
        .in_op              (s_tuser[0]),
        .in_cylinder        (s_tdata[15:0]),
        .in_requester_id    (s_tdata[23:16]),
        .cfg_wr             (cfg_valid && cfg_ready),
        .cfg_data           (cfg_data),
        .res_status         (res_status),
        .res_grant_id       (res_grant_id),
        .res_grant_cylinder (res_grant_cylinder)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_tdata_reg <= {res_grant_cylinder, res_grant_id};
            m_tuser_reg <= res_status;
        end
    end

endmodule

@@ hw/rtl/cdrs_ctrl.sv @@
// Controller state machine of the disk head scheduler.
module cdrs_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic                   out_free,
    input  cdrs_pkg::dp_status_t   dp_status,
    output cdrs_pkg::ctrl_cmd_t    cmd
);

    cdrs_pkg::state_t state_reg;
    cdrs_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdrs_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cdrs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = cdrs_pkg::ST_CHECK;
                end
            end
            cdrs_pkg::ST_CHECK: begin
                if (dp_status.fast_path) begin
                    state_next = cdrs_pkg::ST_RESULT;
                end else begin
                    state_next = cdrs_pkg::ST_SCAN;
                end
            end
            cdrs_pkg::ST_SCAN: begin
                if (dp_status.scan_last) begin
                    state_next = cdrs_pkg::ST_DRAIN;
                end
            end
            cdrs_pkg::ST_DRAIN:  state_next = cdrs_pkg::ST_COMMIT;
            cdrs_pkg::ST_COMMIT: state_next = cdrs_pkg::ST_RESULT;
            cdrs_pkg::ST_RESULT: begin
                if (out_free) begin
                    state_next = cdrs_pkg::ST_IDLE;
                end
            end
            default: state_next = cdrs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            cdrs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            cdrs_pkg::ST_CHECK: begin
                cmd.fast_commit = dp_status.fast_path;
                cmd.scan_start  = !dp_status.fast_path;
            end
            cdrs_pkg::ST_SCAN:   cmd.scan_issue = 1'b1;
            cdrs_pkg::ST_DRAIN:  cmd           = '0;
            cdrs_pkg::ST_COMMIT: cmd.commit    = 1'b1;
            cdrs_pkg::ST_RESULT: cmd.out_load  = out_free;
            default:             cmd           = '0;
        endcase
    end

endmodule

@@ hw/rtl/cdrs_dp.sv @@
// Datapath of the disk head scheduler: head state, slot memory and the slot scan.
module cdrs_dp #(
    parameter int unsigned PENDING_SLOTS = cdrs_pkg::PENDING_SLOTS_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cdrs_pkg::ctrl_cmd_t   cmd,
    output cdrs_pkg::dp_status_t  dp_status,
    input  logic                  in_op,
    input  logic [15:0]           in_cylinder,
    input  logic [7:0]            in_requester_id,
    input  logic                  cfg_wr,
    input  logic [15:0]           cfg_data,
    output logic [2:0]            res_status,
    output logic [7:0]            res_grant_id,
    output logic [15:0]           res_grant_cylinder
);

    localparam int unsigned IDX_W = $clog2(PENDING_SLOTS);

    // Accepted item
    logic        op_reg;
    logic [15:0] cyl_reg;
    logic [7:0]  id_reg;

    // Scheduler state
    logic                     head_busy_reg, head_busy_next;
    logic [15:0]              head_cyl_reg, head_cyl_next;
    logic                     sweep_reg, sweep_next;
    logic [15:0]              arrival_reg, arrival_next;
    logic [PENDING_SLOTS-1:0] valid_reg, valid_next;
    logic [15:0]              max_cyl_reg;

    cdrs_pkg::entry_t mem [PENDING_SLOTS];
    cdrs_pkg::entry_t rd_data_reg;
    cdrs_pkg::entry_t wr_entry;
    logic             mem_we;

    // Scan
    logic [IDX_W-1:0] scan_idx_reg;
    logic             cmp_en_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    cdrs_pkg::cand_t  cur_reg, cur_next;
    cdrs_pkg::cand_t  oth_reg, oth_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic [IDX_W-1:0] oth_idx_reg, oth_idx_next;
    logic             free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;

    logic             rd_valid;
    logic [15:0]      rd_age;
    logic             hit_cur, hit_oth;

    // Result
    logic [2:0]  res_status_reg, res_status_next;
    logic [7:0]  res_id_reg, res_id_next;
    logic [15:0] res_cyl_reg, res_cyl_next;

    assign dp_status.fast_path = (op_reg == cdrs_pkg::OP_REQUEST)
                                 && ((cyl_reg > max_cyl_reg) || !head_busy_reg);
    assign dp_status.scan_last = (scan_idx_reg == IDX_W'(PENDING_SLOTS - 1));

    assign res_status         = res_status_reg;
    assign res_grant_id       = res_id_reg;
    assign res_grant_cylinder = res_cyl_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg  <= in_op;
            cyl_reg <= in_cylinder;
            id_reg  <= in_requester_id;
        end
    end

    // Compare stage: the entry read in the previous cycle against the best so far.
    always_comb begin
        rd_valid = valid_reg[cmp_idx_reg];
        rd_age   = arrival_reg - rd_data_reg.arrival;
        hit_cur  = cmp_en_reg && rd_valid && (rd_data_reg.sweep == sweep_reg);
        hit_oth  = cmp_en_reg && rd_valid && (rd_data_reg.sweep != sweep_reg);

        cur_next        = cur_reg;
        oth_next        = oth_reg;
        cur_idx_next    = cur_idx_reg;
        oth_idx_next    = oth_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;

        if (cmd.scan_start) begin
            cur_next        = '0;
            oth_next        = '0;
            free_found_next = 1'b0;
        end else begin
            if (hit_cur && (!cur_reg.found || (rd_data_reg.cylinder < cur_reg.cylinder)
                    || ((rd_data_reg.cylinder == cur_reg.cylinder) && (rd_age > cur_reg.age)))) begin
                cur_next     = {1'b1, rd_data_reg.cylinder, rd_data_reg.requester, rd_age};
                cur_idx_next = cmp_idx_reg;
            end
            if (hit_oth && (!oth_reg.found || (rd_data_reg.cylinder < oth_reg.cylinder)
                    || ((rd_data_reg.cylinder == oth_reg.cylinder) && (rd_age > oth_reg.age)))) begin
                oth_next     = {1'b1, rd_data_reg.cylinder, rd_data_reg.requester, rd_age};
                oth_idx_next = cmp_idx_reg;
            end
            if (cmp_en_reg && !rd_valid && !free_found_reg) begin
                free_found_next = 1'b1;
                free_idx_next   = cmp_idx_reg;
            end
        end
    end

    // Update of the scheduler state and the result.
    always_comb begin
        head_busy_next  = head_busy_reg;
        head_cyl_next   = head_cyl_reg;
        sweep_next      = sweep_reg;
        arrival_next    = arrival_reg;
        valid_next      = valid_reg;
        mem_we          = 1'b0;
        wr_entry.cylinder  = cyl_reg;
        wr_entry.requester = id_reg;
        wr_entry.sweep     = (cyl_reg > head_cyl_reg) ? sweep_reg : !sweep_reg;
        wr_entry.arrival   = arrival_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_cyl_next    = res_cyl_reg;

        if (cmd.fast_commit) begin
            if (cyl_reg > max_cyl_reg) begin
                res_status_next = cdrs_pkg::STAT_INVALID;
                res_id_next     = '0;
                res_cyl_next    = '0;
            end else begin
                head_busy_next  = 1'b1;
                head_cyl_next   = cyl_reg;
                res_status_next = cdrs_pkg::STAT_GRANTED;
                res_id_next     = id_reg;
                res_cyl_next    = cyl_reg;
            end
        end else if (cmd.commit) begin
            res_id_next  = '0;
            res_cyl_next = '0;
            if (op_reg == cdrs_pkg::OP_REQUEST) begin
                if (free_found_reg) begin
                    mem_we                    = 1'b1;
                    valid_next[free_idx_reg]  = 1'b1;
                    arrival_next              = arrival_reg + 16'd1;
                    res_status_next           = cdrs_pkg::STAT_QUEUED;
                end else begin
                    res_status_next = cdrs_pkg::STAT_FULL;
                end
            end else if (cur_reg.found) begin
                valid_next[cur_idx_reg] = 1'b0;
                head_busy_next  = 1'b1;
                head_cyl_next   = cur_reg.cylinder;
                res_status_next = cdrs_pkg::STAT_GRANTED;
                res_id_next     = cur_reg.requester;
                res_cyl_next    = cur_reg.cylinder;
            end else if (oth_reg.found) begin
                // Current sweep is exhausted: the next sweep becomes current.
                valid_next[oth_idx_reg] = 1'b0;
                sweep_next      = !sweep_reg;
                head_busy_next  = 1'b1;
                head_cyl_next   = oth_reg.cylinder;
                res_status_next = cdrs_pkg::STAT_GRANTED;
                res_id_next     = oth_reg.requester;
                res_cyl_next    = oth_reg.cylinder;
            end else begin
                head_busy_next  = 1'b0;
                res_status_next = cdrs_pkg::STAT_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_busy_reg  <= 1'b0;
            head_cyl_reg   <= '0;
            sweep_reg      <= 1'b0;
            arrival_reg    <= '0;
            valid_reg      <= '0;
            max_cyl_reg    <= cdrs_pkg::MAX_CYLINDER_RESET;
            scan_idx_reg   <= '0;
            cmp_en_reg     <= 1'b0;
            free_found_reg <= 1'b0;
            cur_reg        <= '0;
            oth_reg        <= '0;
        end else begin
            head_busy_reg  <= head_busy_next;
            head_cyl_reg   <= head_cyl_next;
            sweep_reg      <= sweep_next;
            arrival_reg    <= arrival_next;
            valid_reg      <= valid_next;
            if (cfg_wr) begin
                max_cyl_reg <= cfg_data;
            end
            if (cmd.scan_start) begin
                scan_idx_reg <= '0;
            end else if (cmd.scan_issue) begin
                scan_idx_reg <= scan_idx_reg + IDX_W'(1);
            end
            cmp_en_reg     <= cmd.scan_issue;
            free_found_reg <= free_found_next;
            cur_reg        <= cur_next;
            oth_reg        <= oth_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmp_idx_reg    <= scan_idx_reg;
        cur_idx_reg    <= cur_idx_next;
        oth_idx_reg    <= oth_idx_next;
        free_idx_reg   <= free_idx_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_cyl_reg    <= res_cyl_next;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[free_idx_reg] <= wr_entry;
        end
        if (cmd.scan_issue) begin
            rd_data_reg <= mem[scan_idx_reg];
        end
    end

    // An idle head never has requests waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !head_busy_reg |-> (valid_reg == '0))
        else $error("pending slots while head idle");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (op_reg == cdrs_pkg::OP_REQUEST) && free_found_reg)
        |=> ($countones(valid_reg) == $past($countones(valid_reg)) + 1))
        else $error("queued request did not occupy exactly one slot");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.commit && (op_reg == cdrs_pkg::OP_RELEASE) && (cur_reg.found || oth_reg.found))
        |=> (head_busy_reg && (head_cyl_reg == res_cyl_reg)
             && ($countones(valid_reg) + 1 == $past($countones(valid_reg)))))
        else $error("release grant inconsistent with head or slot state");

endmodule

@@ test/cscan_disk_request_scheduler_unit_checker.sv @@
// Scoreboard for the circular-scan scheduler: watches the channels, predicts each grant and compares.
module cscan_disk_request_scheduler_unit_checker #(
    parameter int unsigned SLOTS = cdrs_pkg::PENDING_SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] cylinder, [23:16] requester_id
    input  logic [0:0]  s_tuser,   // [0] op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [7:0] grant_id, [23:8] grant_cylinder
    input  logic [2:0]  m_tuser,   // [2:0] status
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output int          fail_count,
    output int          results_outstanding,
    output int          results_checked,
    output logic [4:0]  statuses_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        cdrs_pkg::status_t status;
        logic [7:0]        grant_id;
        logic [15:0]       grant_cyl;
    } grant_t;

    // Private copy of the scheduler state.
    logic [15:0] max_cyl;
    bit          head_busy;
    logic [15:0] head_cyl;
    bit          cur_sweep;
    bit          slot_valid   [SLOTS];
    logic [15:0] slot_cyl     [SLOTS];
    logic [7:0]  slot_id      [SLOTS];
    bit          slot_sweep   [SLOTS];
    logic [15:0] slot_arrival [SLOTS];
    logic [15:0] arrival_count;

    grant_t      expected_grants[$];
    int          errors  = 0;
    int          checked = 0;
    logic [4:0]  seen    = '0;

    // Lowest cylinder of one sweep; among equal cylinders the one that has waited longest.
    function automatic int lowest_oldest_slot(bit sweep);
        int          best;
        logic [15:0] best_age;
        logic [15:0] age;
        best     = -1;
        best_age = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (slot_valid[i] && slot_sweep[i] == sweep) begin
                age = arrival_count - slot_arrival[i];
                if (best < 0 || slot_cyl[i] < slot_cyl[best] ||
                    (slot_cyl[i] == slot_cyl[best] && age > best_age)) begin
                    best     = i;
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    function automatic grant_t schedule_item(cdrs_pkg::op_t op, logic [15:0] cyl,
                                             logic [7:0] id);
        grant_t g;
        int     slot;
        g.status    = cdrs_pkg::STAT_GRANTED;
        g.grant_id  = '0;
        g.grant_cyl = '0;
        slot        = -1;
        if (op == cdrs_pkg::OP_REQUEST) begin
            if (cyl > max_cyl) begin
                g.status = cdrs_pkg::STAT_INVALID;
            end else if (!head_busy) begin
                head_busy   = 1'b1;
                head_cyl    = cyl;
                g.grant_id  = id;
                g.grant_cyl = cyl;
            end else begin
                for (int i = SLOTS - 1; i >= 0; i--) begin
                    if (!slot_valid[i])
                        slot = i;
                end
                if (slot < 0) begin
                    g.status = cdrs_pkg::STAT_FULL;
                end else begin
                    slot_valid[slot]   = 1'b1;
                    slot_cyl[slot]     = cyl;
                    slot_id[slot]      = id;
                    // At or below the head waits for the next sweep.
                    slot_sweep[slot]   = (cyl > head_cyl) ? cur_sweep : !cur_sweep;
                    slot_arrival[slot] = arrival_count;
                    arrival_count      = arrival_count + 16'd1;
                    g.status           = cdrs_pkg::STAT_QUEUED;
                end
            end
        end else begin
            slot = lowest_oldest_slot(cur_sweep);
            if (slot < 0) begin
                slot = lowest_oldest_slot(!cur_sweep);
                if (slot >= 0)
                    cur_sweep = !cur_sweep;
            end
            if (slot < 0) begin
                head_busy = 1'b0;
                g.status  = cdrs_pkg::STAT_IDLE;
            end else begin
                slot_valid[slot] = 1'b0;
                head_busy        = 1'b1;
                head_cyl         = slot_cyl[slot];
                g.grant_id       = slot_id[slot];
                g.grant_cyl      = slot_cyl[slot];
            end
        end
        return g;
    endfunction

    always @(posedge aclk) begin
        grant_t want;
        if (!aresetn) begin
            max_cyl       = cdrs_pkg::MAX_CYLINDER_RESET;
            head_busy     = 1'b0;
            head_cyl      = '0;
            cur_sweep     = 1'b0;
            arrival_count = '0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_valid[i]   = 1'b0;
                slot_cyl[i]     = '0;
                slot_id[i]      = '0;
                slot_sweep[i]   = 1'b0;
                slot_arrival[i] = '0;
            end
            expected_grants.delete();
        end else begin
            if (cfg_valid && cfg_ready)
                max_cyl = cfg_data;
            // A result leaving at this edge belongs to an earlier item, so compare first.
            if (m_tvalid && m_tready) begin
                if (expected_grants.size() == 0) begin
                    $error("unexpected result item: status %0d, grant_id %0d, grant_cylinder %0d",
                           m_tuser, m_tdata[7:0], m_tdata[23:8]);
                    errors++;
                end else begin
                    want = expected_grants.pop_front();
                    checked++;
                    seen[int'(want.status)] = 1'b1;
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata[7:0] !== want.grant_id) begin
                        $error("grant_id: expected %0d, got %0d", want.grant_id, m_tdata[7:0]);
                        errors++;
                    end
                    if (m_tdata[23:8] !== want.grant_cyl) begin
                        $error("grant_cylinder: expected %0d, got %0d",
                               want.grant_cyl, m_tdata[23:8]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                expected_grants.insert(expected_grants.size(),
                                       schedule_item(cdrs_pkg::op_t'(s_tuser[0]),
                                                     s_tdata[15:0], s_tdata[23:16]));
        end
        fail_count          <= errors;
        results_outstanding <= expected_grants.size();
        results_checked     <= checked;
        statuses_seen       <= seen;
    end

endmodule

@@ test/cscan_disk_request_scheduler_unit_test.sv @@
// Stimulus and verdict for the circular-scan scheduler, with the scoreboard beside the block.
module cscan_disk_request_scheduler_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [15:0] cylinder, [23:16] requester_id
    logic [0:0]  s_tuser;   // [0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;   // [7:0] grant_id, [23:8] grant_cylinder
    logic [2:0]  m_tuser;   // [2:0] status
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    int          fail_count;
    int          results_outstanding;
    int          results_checked;
    logic [4:0]  statuses_seen;

    int          items_sent     = 0;
    int          settings_used  = 1;
    int          src_idle_pct   = 0;
    int          sink_stall_pct = 0;
    int          hold_asked     = 0;
    int          hold_taken     = 0;
    int          quiet_cycles   = 0;
    logic [15:0] max_now        = cdrs_pkg::MAX_CYLINDER_RESET;

    cscan_disk_request_scheduler_unit u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    cscan_disk_request_scheduler_unit_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_tvalid            (s_tvalid),
        .s_tready            (s_tready),
        .s_tdata             (s_tdata),
        .s_tuser             (s_tuser),
        .m_tvalid            (m_tvalid),
        .m_tready            (m_tready),
        .m_tdata             (m_tdata),
        .m_tuser             (m_tuser),
        .cfg_valid           (cfg_valid),
        .cfg_ready           (cfg_ready),
        .cfg_data            (cfg_data),
        .fail_count          (fail_count),
        .results_outstanding (results_outstanding),
        .results_checked     (results_checked),
        .statuses_seen       (statuses_seen)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: random stalls, plus one long hold-off when asked for.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_taken < hold_asked) begin
                hold_taken++;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no item moved for %0d cycles.", quiet_cycles);
            $display("cscan_disk_request_scheduler_unit_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(cdrs_pkg::op_t op, logic [15:0] cyl, logic [7:0] id);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {id, cyl};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // Stop offering items and wait until every grant has come back.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_outstanding != 0)
            @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_cyl_limit(logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_now = value;
        settings_used++;
    endtask

    function automatic logic [15:0] pick_cylinder();
        int lim;
        int c;
        lim = int'(max_now);
        case ($urandom_range(0, 9))
            0: c = (lim == 65535) ? $urandom_range(0, 65535) : $urandom_range(lim + 1, 65535);
            1: c = 0;
            2: c = lim;
            // A narrow band in the middle gives plenty of equal cylinders.
            3, 4: c = $urandom_range(lim / 2, (lim / 2 + 3 > lim) ? lim : lim / 2 + 3);
            default: c = $urandom_range(0, lim);
        endcase
        return 16'(c);
    endfunction

    // Bursts of requests fill the table towards full; bursts of releases drain it to idle.
    task automatic run_random(int count, int idle_pct, int stall_pct);
        int  left;
        int  burst;
        bit  releasing;
        bit  op_bit;
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        left           = count;
        while (left > 0) begin
            releasing = $urandom_range(0, 1);
            burst     = $urandom_range(1, 20);
            for (int k = 0; k < burst && left > 0; k++) begin
                op_bit = ($urandom_range(0, 99) < 10) ? !releasing : releasing;
                send_item(cdrs_pkg::op_t'(op_bit), pick_cylinder(),
                          8'($urandom_range(0, 255)));
                left--;
            end
        end
    endtask

    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part at the reset limit of 199.
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);   // release while idle
        send_item(cdrs_pkg::OP_REQUEST, 16'd200,   8'h01);   // just above the limit
        send_item(cdrs_pkg::OP_REQUEST, 16'hFFFF,  8'hFF);   // far above the limit
        send_item(cdrs_pkg::OP_REQUEST, 16'd100,   8'h00);   // idle head: granted at once
        send_item(cdrs_pkg::OP_REQUEST, 16'd150,   8'h11);
        send_item(cdrs_pkg::OP_REQUEST, 16'd150,   8'h12);   // same cylinder, later arrival
        send_item(cdrs_pkg::OP_REQUEST, 16'd199,   8'hFF);
        send_item(cdrs_pkg::OP_REQUEST, 16'd100,   8'h13);   // at the head: next sweep
        send_item(cdrs_pkg::OP_REQUEST, 16'd0,     8'h14);
        send_item(cdrs_pkg::OP_REQUEST, 16'd0,     8'h15);
        send_item(cdrs_pkg::OP_RELEASE, 16'hFFFF,  8'hFF);
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);
        send_item(cdrs_pkg::OP_REQUEST, 16'd160,   8'h16);   // above the head: this sweep
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);   // sweep empty: the sweeps swap
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);   // nothing left: head goes idle
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);
        send_item(cdrs_pkg::OP_REQUEST, 16'd199,   8'h20);
        send_item(cdrs_pkg::OP_REQUEST, 16'd0,     8'hA5);
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);
        send_item(cdrs_pkg::OP_RELEASE, 16'd0,     8'h00);
        drain();

        write_cyl_limit(16'd0);
        run_random(30, 73, 0);
        drain();

        write_cyl_limit(16'hFFFF);
        run_random(160, 0, 73);
        drain();

        write_cyl_limit(16'd1000);
        run_random(160, 13, 13);
        drain();

        // The result side holds off for a long stretch while items keep coming.
        write_cyl_limit(16'd63);
        hold_asked++;
        run_random(120, 0, 0);
        drain();

        write_cyl_limit(16'($urandom_range(1, 65534)));
        run_random(150, 73, 0);
        drain();

        write_cyl_limit(cdrs_pkg::MAX_CYLINDER_RESET);
        run_random(130, 0, 0);
        drain();

        $display("Sent %0d items under %0d cylinder limits and four flow-control modes.",
                 items_sent, settings_used);
        $display("Compared %0d grants; kinds seen (idle,full,invalid,queued,granted) = %b.",
                 results_checked, statuses_seen);
        if (fail_count == 0) begin
            $display("cscan_disk_request_scheduler_unit_test: PASS");
        end else begin
            $display("cscan_disk_request_scheduler_unit_test: FAIL");
        end
        $finish;
    end

endmodule
